@@ rtl/core/stream_search_replace_defines.svh @@
// Assertion macros for the file that checks its own logic.
`ifndef STREAM_SEARCH_REPLACE_DEFINES_SVH
`define STREAM_SEARCH_REPLACE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/ssr_pkg.sv @@
package ssr_pkg;

    localparam int DEF_MAX_PATTERN = 8;
    // The replacement field is 64 bits wide, so a job carries at most eight bytes.
    localparam int MAX_RESULTS = 8;
    localparam int RCW = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_TEXT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_LEN   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_TEXT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_LEN  = CFG_INDEX_W'(3);

    typedef struct packed {
        logic                   wr;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } ssr_cfg_t;

    // All output words caused by one input word.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [RCW-1:0]              count;
        logic                        marker;
        logic                        last;
    } ssr_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ssr_qstat_t;

endpackage

@@ rtl/core/ssr_front.sv @@
module ssr_front
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ssr_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_byte_valid,
    input  logic       string_last,
    input  ssr_qstat_t qstat,
    output logic       push,
    output ssr_job_t   push_job
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [7:0]      win_reg [MAX_PATTERN];
    logic [7:0]      win_next [MAX_PATTERN];
    logic [CW-1:0]   count_reg, count_next;
    logic [63:0]     search_text_reg, search_text_next;
    logic [3:0]      search_len_reg, search_len_next;
    logic [63:0]     replace_text_reg, replace_text_next;
    logic [3:0]      replace_len_reg, replace_len_next;

    logic [CW-1:0]   slen;
    logic [RCW-1:0]  rlen;
    logic            take;
    logic [7:0]      ext [MAX_PATTERN];
    logic [CW-1:0]   extc;
    logic            full;
    logic [MAX_PATTERN-1:0] ok;
    logic            hit;
    logic            accept;
    ssr_job_t        job;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        slen = (search_len_reg > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : search_len_reg[CW-1:0];
        rlen = (replace_len_reg > 4'(MAX_RESULTS)) ? RCW'(MAX_RESULTS)
                                                   : replace_len_reg[RCW-1:0];
        take = in_byte_valid && (slen != '0);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            ext[i] = (take && count_reg == CW'(i)) ? in_byte : win_reg[i];
            ok[i]  = (CW'(i) >= slen) || (ext[i] == search_text_reg[8*i +: 8]);
        end
        extc = count_reg + CW'(take);
        full = take && (extc == slen);
        hit  = full && (&ok);

        job        = '0;
        job.last   = string_last;
        win_next   = ext;
        count_next = extc;
        if (hit)
        begin
            job.bytes  = replace_text_reg;
            job.count  = rlen;
            count_next = '0;
        end
        else if (string_last)
        begin
            // The end of the string flushes whatever the window holds.
            if (slen == '0)
            begin
                job.bytes[0] = in_byte;
                job.count    = RCW'(in_byte_valid);
            end
            else
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    job.bytes[i] = ext[i];
                end
                job.count = RCW'(extc);
            end
            count_next = '0;
        end
        else if (slen == '0)
        begin
            job.bytes[0] = in_byte;
            job.count    = RCW'(in_byte_valid);
        end
        else if (full)
        begin
            job.bytes[0] = ext[0];
            job.count    = RCW'(1);
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_next[i] = ext[i+1];
            end
            win_next[MAX_PATTERN-1] = '0;
            count_next = slen - CW'(1);
        end
        if (string_last && job.count == '0)
        begin
            // An end marker carries a zero byte.
            job.bytes  = '0;
            job.marker = 1'b1;
            job.count  = RCW'(1);
        end

        if (!accept)
        begin
            win_next   = win_reg;
            count_next = count_reg;
        end

        search_text_next  = search_text_reg;
        search_len_next   = search_len_reg;
        replace_text_next = replace_text_reg;
        replace_len_next  = replace_len_reg;
        if (cfg.wr)
        begin
            case (cfg.index)
                REG_SEARCH_TEXT:
                begin
                    search_text_next = cfg.data;
                    count_next       = '0;
                end
                REG_SEARCH_LEN:
                begin
                    search_len_next = cfg.data[3:0];
                    count_next      = '0;
                end
                REG_REPLACE_TEXT: replace_text_next = cfg.data;
                REG_REPLACE_LEN:  replace_len_next  = cfg.data[3:0];
                default: ;
            endcase
        end
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            search_text_reg  <= '0;
            search_len_reg   <= '0;
            replace_text_reg <= '0;
            replace_len_reg  <= '0;
        end
        else
        begin
            count_reg        <= count_next;
            search_text_reg  <= search_text_next;
            search_len_reg   <= search_len_next;
            replace_text_reg <= replace_text_next;
            replace_len_reg  <= replace_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

@@ rtl/core/ssr_queue.sv @@
module ssr_queue
    import ssr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ssr_job_t   push_job,
    input  logic       pop,
    output ssr_job_t   head_job,
    output ssr_qstat_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ssr_job_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;

    assign qstat.full  = (fill_reg == NW'(DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign head_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/core/ssr_back.sv @@
module ssr_back
    import ssr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ssr_qstat_t qstat,
    input  ssr_job_t   head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_byte_valid,
    output logic       run_last,
    output logic       string_end
);

    localparam int IW = $clog2(MAX_RESULTS);

    logic [IW-1:0] idx_reg, idx_next;
    logic          fire;

    assign out_valid      = !qstat.empty;
    assign out_byte       = head_job.bytes[idx_reg];
    assign out_byte_valid = !head_job.marker;
    // The last word of a job is the one whose position plus one equals its count.
    assign run_last       = (RCW'(idx_reg) + RCW'(1)) == head_job.count;
    assign string_end     = run_last && head_job.last;
    assign fire           = out_valid && out_ready;
    assign pop            = fire && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = run_last ? '0 : idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ rtl/core/stream_search_replace.sv @@
// Stream search and replace. One byte word enters per cycle while the two-entry job
// queue between the matching front end and the output sequencer has room; a word that
// causes k output words (a replacement burst, or a window flush at the end of a string)
// has them sent one word per cycle, so the sustained input rate is one word per cycle
// whenever each input word causes at most one output word and out_ready stays high.
// Each job is queued when its input word is accepted and offered from the queue head.
// Configuration writes are taken every cycle and must be made while the block is idle.
`include "stream_search_replace_defines.svh"

module stream_search_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_byte_valid,
    input  logic                   string_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_byte_valid,
    output logic                   run_last,
    output logic                   string_end
);

    ssr_cfg_t   cfg;
    ssr_qstat_t qstat;
    ssr_job_t   push_job;
    ssr_job_t   head_job;
    logic       push;
    logic       pop;

    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ssr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .in_byte_valid (in_byte_valid),
        .string_last   (string_last),
        .qstat         (qstat),
        .push          (push),
        .push_job      (push_job)
    );

    ssr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    ssr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .head_job       (head_job),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .run_last       (run_last),
        .string_end     (string_end)
    );

    // A job that still has words to send keeps the output valid.
    `SSR_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid)
    // An end marker is always a lone word that closes the string.
    `SSR_ASSERT_IMPL(a_marker_closes, out_valid && !out_byte_valid, run_last && string_end)
    // Input is held off only while queued work is waiting at the output.
    `SSR_ASSERT_IMPL(a_stall_has_work, !in_ready, out_valid && !qstat.empty)

endmodule

@@ verif/ssr_replace_checker.sv @@
`timescale 1ns / 100ps

module ssr_replace_checker
    import ssr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_byte_valid,
    input  logic                   string_last,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [7:0]             out_byte,
    input  logic                   out_byte_valid,
    input  logic                   run_last,
    input  logic                   string_end,
    output int                     errors,
    output int                     pending
);

    localparam int WIN_MAX  = DEF_MAX_PATTERN;
    localparam int REPL_MAX = CFG_DATA_W / 8;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       run_done;
        logic       str_done;
    } text_word_t;

    text_word_t            expected_words[$];
    logic [CFG_DATA_W-1:0] search_bytes;
    logic [3:0]            search_count;
    logic [CFG_DATA_W-1:0] replace_bytes;
    logic [3:0]            replace_count;
    logic [7:0]            window[WIN_MAX];
    int                    window_fill;
    int                    mismatches = 0;

    function automatic int clamp_len(input logic [3:0] len, input int limit);
        return (int'(len) > limit) ? limit : int'(len);
    endfunction

    // Works out every output word that one accepted input word causes and queues them.
    function automatic void predict_words(input logic [7:0] b, input logic b_valid,
                                          input logic last);
        text_word_t burst[$];
        text_word_t word;
        int         slen;
        int         rlen;
        int         i;
        bit         hit;
        slen = clamp_len(search_count, WIN_MAX);
        rlen = clamp_len(replace_count, REPL_MAX);
        if (b_valid)
        begin
            if (slen == 0)
            begin
                burst.push_back(text_word_t'{b, 1'b1, 1'b0, 1'b0});
            end
            else
            begin
                if (window_fill < WIN_MAX)
                begin
                    window[window_fill] = b;
                    window_fill++;
                end
                if (window_fill >= slen)
                begin
                    hit = 1'b1;
                    for (i = 0; i < slen; i++)
                    begin
                        if (window[i] != search_bytes[8*i +: 8])
                            hit = 1'b0;
                    end
                    if (hit)
                    begin
                        for (i = 0; i < rlen; i++)
                            burst.push_back(text_word_t'{replace_bytes[8*i +: 8], 1'b1,
                                                         1'b0, 1'b0});
                        window_fill = 0;
                    end
                    else
                    begin
                        burst.push_back(text_word_t'{window[0], 1'b1, 1'b0, 1'b0});
                        for (i = 1; i < WIN_MAX; i++)
                            window[i-1] = window[i];
                        window[WIN_MAX-1] = 8'h00;
                        window_fill--;
                    end
                end
            end
        end
        if (last)
        begin
            for (i = 0; i < window_fill; i++)
                burst.push_back(text_word_t'{window[i], 1'b1, 1'b0, 1'b0});
            window_fill = 0;
            // A string must always close, so an empty flush still yields an end marker.
            if (burst.size() == 0)
                burst.push_back(text_word_t'{8'h00, 1'b0, 1'b0, 1'b0});
        end
        for (i = 0; i < burst.size(); i++)
        begin
            word = burst[i];
            if (i == burst.size() - 1)
            begin
                word.run_done = 1'b1;
                word.str_done = last;
            end
            expected_words.push_back(word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        text_word_t want;
        int         j;
        if (!rst_n)
        begin
            expected_words.delete();
            search_bytes  = '0;
            search_count  = '0;
            replace_bytes = '0;
            replace_count = '0;
            window_fill   = 0;
            for (j = 0; j < WIN_MAX; j++)
                window[j] = 8'h00;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected output word: out_byte %02h, out_byte_valid %0b",
                           out_byte, out_byte_valid);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_byte !== want.data)
                    begin
                        mismatches++;
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    end
                    if (out_byte_valid !== want.data_valid)
                    begin
                        mismatches++;
                        $error("out_byte_valid: expected %0b, got %0b", want.data_valid,
                               out_byte_valid);
                    end
                    if (run_last !== want.run_done)
                    begin
                        mismatches++;
                        $error("run_last: expected %0b, got %0b", want.run_done, run_last);
                    end
                    if (string_end !== want.str_done)
                    begin
                        mismatches++;
                        $error("string_end: expected %0b, got %0b", want.str_done,
                               string_end);
                    end
                end
            end
            // Any change to the pattern throws away whatever the window held.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEARCH_TEXT:
                    begin
                        search_bytes = cfg_data;
                        window_fill  = 0;
                    end
                    REG_SEARCH_LEN:
                    begin
                        search_count = cfg_data[3:0];
                        window_fill  = 0;
                    end
                    REG_REPLACE_TEXT: replace_bytes = cfg_data;
                    REG_REPLACE_LEN:  replace_count = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_words(in_byte, in_byte_valid, string_last);
            pending <= expected_words.size();
        end
        errors <= mismatches;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ssr_pkg::*;

    localparam int         DRAIN_CYCLES = 8;
    localparam int         TAIL_CYCLES  = 20;
    localparam int         WORDS_PER_SETTING = 20;
    localparam logic [7:0] ALPHA_BASE   = 8'h61;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             in_byte;
    logic                   in_byte_valid;
    logic                   string_last;
    logic                   out_valid;
    logic                   out_ready;
    logic [7:0]             out_byte;
    logic                   out_byte_valid;
    logic                   run_last;
    logic                   string_end;
    int                     errors;
    int                     pending;

    int                     send_idle_pct = 27;
    int                     recv_idle_pct = 54;
    int                     hold_cycles   = 0;
    int                     items_sent    = 0;
    logic [CFG_DATA_W-1:0]  cur_search    = '0;
    int                     cur_slen      = 0;

    stream_search_replace DUT (.*);

    ssr_replace_checker u_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stops offering words and waits until every predicted word has come out.
    task automatic quiesce();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_word(input logic [7:0] b, input logic b_valid, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_byte       = b;
        in_byte_valid = b_valid;
        string_last   = last;
        in_valid      = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (b_valid || last)
            items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        quiesce();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] search, input logic [3:0] slen,
                              input logic [CFG_DATA_W-1:0] repl, input logic [3:0] rlen);
        write_reg(REG_SEARCH_TEXT, search);
        write_reg(REG_SEARCH_LEN, CFG_DATA_W'(slen));
        write_reg(REG_REPLACE_TEXT, repl);
        write_reg(REG_REPLACE_LEN, CFG_DATA_W'(rlen));
        cur_search = search;
        cur_slen   = (int'(slen) > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : int'(slen);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] pat;
        logic [3:0]            slen;
        logic [3:0]            rlen;
        int                    i;
        // Pattern bytes come mostly from a tiny alphabet so that near misses are common.
        for (i = 0; i < CFG_DATA_W / 8; i++)
            pat[8*i +: 8] = ($urandom_range(0, 9) < 8) ? 8'(ALPHA_BASE + $urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       slen = 4'd0;
            1:       slen = 4'd1;
            2:       slen = 4'd8;
            3:       slen = 4'($urandom_range(9, 15));
            default: slen = 4'($urandom_range(2, 5));
        endcase
        case ($urandom_range(0, 7))
            0:       rlen = 4'd0;
            1:       rlen = 4'd8;
            2:       rlen = 4'($urandom_range(9, 15));
            default: rlen = 4'($urandom_range(1, 4));
        endcase
        set_config(pat, slen, {$urandom, $urandom}, rlen);
    endtask

    // One string: whole and partial pattern occurrences mixed with other bytes and
    // ignored empty words, closed by a last word that may or may not carry a byte.
    task automatic send_text(input int n_items);
        int k;
        int j;
        int run;
        int pick;
        k = 0;
        while (k < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                quiesce();
            end
            else if (pick < 40 && cur_slen > 0)
            begin
                for (j = 0; j < cur_slen; j++)
                    send_word(cur_search[8*j +: 8], 1'b1, 1'b0);
                k += cur_slen;
            end
            else if (pick < 60 && cur_slen > 1)
            begin
                run = $urandom_range(1, cur_slen - 1);
                for (j = 0; j < run; j++)
                    send_word(cur_search[8*j +: 8], 1'b1, 1'b0);
                k += run;
            end
            else if (pick < 66)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            else if (pick < 88)
            begin
                send_word(8'(ALPHA_BASE + $urandom_range(0, 3)), 1'b1, 1'b0);
                k++;
            end
            else
            begin
                send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                k++;
            end
        end
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] pat8;
        int                    i;
        int                    phase;
        int                    target;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        in_byte_valid = 1'b0;
        string_last   = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pass-through with the reset settings, an ignored empty word and a bare end.
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        write_reg(CFG_INDEX_W'($urandom_range(4, 255)), {$urandom, $urandom});

        // Two-byte pattern with a longer replacement, ending on a byte that gets flushed.
        set_config({$urandom, 16'($urandom), 16'h6261}, 4'd2, 64'h0000_0000_005A_5958, 4'd3);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b1);

        // Rewriting the pattern length mid-string drops the byte still held.
        send_word(8'h78, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        write_reg(REG_SEARCH_LEN, CFG_DATA_W'(2));
        send_word(8'h62, 1'b1, 1'b1);

        // Oversized pattern length, matches deleted, so the string closes with a marker.
        pat8 = {$urandom, $urandom};
        set_config(pat8, 4'd12, {$urandom, $urandom}, 4'd0);
        for (i = 0; i < 8; i++)
            send_word(pat8[8*i +: 8], 1'b1, i == 7);

        // Every byte becomes an oversized replacement burst while the output is held off.
        set_config({$urandom, 24'($urandom), 8'h61}, 4'd1, {$urandom, $urandom}, 4'd15);
        hold_cycles = 60;
        for (i = 0; i < 6; i++)
            send_word(8'h61, 1'b1, i == 5);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 27 : 0;
            repeat (3)
            begin
                random_config();
                target = items_sent + WORDS_PER_SETTING;
                while (items_sent < target)
                    send_text($urandom_range(0, 10));
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
